// File: rtl/tlcu_pkg.sv
// Shared types, constants and widths for the limited cell update pipeline.
package tlcu_pkg;

  localparam int VAL_W       = 18;
  localparam int DIFF_W      = 19;
  localparam int ABS_W       = 18;
  localparam int RATIO_W     = 20;
  localparam int PSUM_W      = 21;
  localparam int RATIO_QB    = 20;
  localparam int KOREN_QB    = 18;
  localparam int KOREN_DW    = 37;
  localparam int KOREN_VW    = 20;
  localparam int G_QB        = 18;
  localparam int NUM_W       = 59;
  localparam int AP_W        = 40;
  localparam int UN_W        = 58;
  localparam int UD_W        = 39;
  localparam int COMB_STAGES = 5;

  typedef logic signed [VAL_W-1:0]   val_t;
  typedef logic signed [RATIO_W-1:0] ratio_t;

  localparam ratio_t RATIO_MAX = 20'sh7FFFF;
  localparam ratio_t RATIO_MIN = 20'sh80000;
  localparam ratio_t ONE_Q16   = 20'sh10000;
  localparam logic [KOREN_VW-1:0] TWO_Q16   = 20'd131072;
  localparam logic [KOREN_VW-1:0] KOREN_OFS = 20'd196608;
  localparam val_t VAL_MAX = 18'sh1FFFF;
  localparam val_t VAL_MIN = 18'sh20000;

  typedef enum logic [2:0] {
    MODE_UPWIND  = 3'd0,
    MODE_CENTRAL = 3'd1,
    MODE_RATIO   = 3'd2,
    MODE_KOREN   = 3'd3,
    MODE_MINMOD  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_LIMITER_MODE = 3'd0,
    REG_CONV_COEF    = 3'd1,
    REG_DIFF_COEF    = 3'd2,
    REG_RELAX        = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    val_t  c;
    val_t  e;
    val_t  w;
    val_t  ww;
    val_t  n;
    val_t  s;
    val_t  ss;
    logic  edge_cell;
    mode_e mode;
  } item_t;

  typedef struct packed {
    item_t item;
    logic  flag;
  } stage_t;

endpackage

// File: rtl/tlcu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module tlcu_div #(
  parameter int DW = 34,
  parameter int VW = 18,
  parameter int QB = 20,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          out_valid_o,
  output logic [QB-1:0] quot_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);
  localparam int RW = (DW > VW + QB) ? DW : VW + QB;

  logic [QB:0]   vld_q;
  logic [RW-1:0] rem_q  [QB];
  logic [VW-1:0] dvs_q  [QB];
  logic [QB-1:0] quo_q  [QB+1];
  logic          ovf_q  [QB+1];
  logic [SW-1:0] side_q [QB+1];

  logic [RW-1:0] sub_w [QB];
  logic          ge_w  [QB];
  logic [QB-1:0] quo_w [QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      sub_w[k] = RW'(dvs_q[k]) << (QB - 1 - k);
      ge_w[k]  = rem_q[k] >= sub_w[k];
      quo_w[k] = quo_q[k];
      quo_w[k][QB-1-k] = ge_w[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QB-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RW'(dividend_i);
    dvs_q[0]  <= divisor_i;
    quo_q[0]  <= '0;
    ovf_q[0]  <= (RW'(dividend_i) >> QB) >= RW'(divisor_i);
    side_q[0] <= side_i;
    for (int k = 0; k < QB - 1; k++) begin
      rem_q[k+1] <= ge_w[k] ? rem_q[k] - sub_w[k] : rem_q[k];
      dvs_q[k+1] <= dvs_q[k];
    end
    for (int k = 0; k < QB; k++) begin
      quo_q[k+1]  <= quo_w[k];
      ovf_q[k+1]  <= ovf_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign out_valid_o = vld_q[QB];
  assign quot_o      = quo_q[QB];
  assign ovf_o       = ovf_q[QB];
  assign side_o      = side_q[QB];

endmodule

// File: rtl/tlcu_limiter.sv
// Flux limiter: Koren quotient dividers and per-mode weight selection.
module tlcu_limiter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  tlcu_pkg::stage_t in_i,
  input  tlcu_pkg::ratio_t ratio_i [4],
  output logic             out_valid_o,
  output tlcu_pkg::stage_t out_o,
  output tlcu_pkg::ratio_t phi_o [4]
);
  import tlcu_pkg::*;

  localparam int ST_W = $bits(stage_t);

  logic [KOREN_DW-1:0] kdvd [4];
  logic [KOREN_VW-1:0] kdvs [4];
  logic [KOREN_QB-1:0] kq   [4];
  ratio_t              kr   [4];
  stage_t              kst;
  logic                kv;

  ratio_t              phi_d [4];
  logic                flag_d;
  logic [KOREN_VW-1:0] t_w   [4];
  logic [KOREN_VW:0]   twor_w [4];

  logic   v_q;
  stage_t st_q;
  ratio_t phi_q [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      kdvd[k] = (ratio_i[k] > ratio_t'(0)) ? {ratio_i[k][RATIO_W-2:0], 18'b0} : '0;
      kdvs[k] = KOREN_VW'(ratio_i[k]) + KOREN_OFS;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_koren
    if (k == 0) begin : g_lead
      tlcu_div #(.DW(KOREN_DW), .VW(KOREN_VW), .QB(KOREN_QB), .SW(ST_W + RATIO_W)) u_div (
        .clk_i, .rst_ni,
        .in_valid_i  (in_valid_i),
        .dividend_i  (kdvd[k]),
        .divisor_i   (kdvs[k]),
        .side_i      ({in_i, ratio_i[k]}),
        .out_valid_o (kv),
        .quot_o      (kq[k]),
        .ovf_o       (),
        .side_o      ({kst, kr[k]})
      );
    end else begin : g_lane
      tlcu_div #(.DW(KOREN_DW), .VW(KOREN_VW), .QB(KOREN_QB), .SW(RATIO_W)) u_div (
        .clk_i, .rst_ni,
        .in_valid_i  (in_valid_i),
        .dividend_i  (kdvd[k]),
        .divisor_i   (kdvs[k]),
        .side_i      (ratio_i[k]),
        .out_valid_o (),
        .quot_o      (kq[k]),
        .ovf_o       (),
        .side_o      (kr[k])
      );
    end
  end

  always_comb begin
    flag_d = kst.flag && ((kst.item.mode == MODE_RATIO) || (kst.item.mode == MODE_KOREN) ||
                          (kst.item.mode == MODE_MINMOD));
    for (int k = 0; k < 4; k++) begin
      t_w[k] = {2'b00, kq[k]};
      if (t_w[k] > TWO_Q16) t_w[k] = TWO_Q16;
      twor_w[k] = {kr[k], 1'b0};
      if ({1'b0, t_w[k]} > twor_w[k]) t_w[k] = twor_w[k][KOREN_VW-1:0];
      unique case (kst.item.mode)
        MODE_CENTRAL: phi_d[k] = ONE_Q16;
        MODE_RATIO:   phi_d[k] = kr[k];
        MODE_KOREN:   phi_d[k] = (kr[k] > ratio_t'(0)) ? ratio_t'(t_w[k]) : ratio_t'(0);
        MODE_MINMOD: begin
          if (kr[k] < ratio_t'(0)) phi_d[k] = ratio_t'(0);
          else if (kr[k] > ONE_Q16) phi_d[k] = ONE_Q16;
          else phi_d[k] = kr[k];
        end
        default:      phi_d[k] = ratio_t'(0);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= kv;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q.item <= kst.item;
    st_q.flag <= flag_d;
    phi_q     <= phi_d;
  end

  assign out_valid_o = v_q;
  assign out_o       = st_q;
  assign phi_o       = phi_q;

endmodule

// File: rtl/tlcu_combine.sv
// Coefficient products, weighted neighbor sum and center coefficient.
module tlcu_combine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  tlcu_pkg::stage_t                  in_i,
  input  tlcu_pkg::ratio_t                  phi_i [4],
  input  logic [15:0]                       conv_i,
  input  logic [15:0]                       diff_i,
  output logic                              out_valid_o,
  output tlcu_pkg::stage_t                  out_o,
  output logic signed [tlcu_pkg::NUM_W-1:0] num_o,
  output logic signed [tlcu_pkg::AP_W-1:0]  ap_o
);
  import tlcu_pkg::*;

  logic [COMB_STAGES-1:0] v_q;

  // sums
  stage_t                    st1_q;
  logic signed [DIFF_W-1:0]  en1_q, ws1_q;
  logic [16:0]               md1_q;
  logic signed [PSUM_W-1:0]  pew1_q, pns1_q, pen1_q;
  ratio_t                    pw1_q, ps1_q;
  // products
  stage_t                    st2_q;
  logic signed [38:0]        wpew2_q, spns2_q, wwpw2_q, ssps2_q;
  logic signed [35:0]        den2_q;
  logic signed [36:0]        mdws2_q;
  logic signed [37:0]        mpen2_q;
  // reduce
  stage_t                    st3_q;
  logic signed [40:0]        x3_q;
  logic signed [37:0]        y3_q;
  logic signed [AP_W-1:0]    ap3_q;
  logic [18:0]               base_w;
  // split product
  stage_t                    st4_q;
  logic [36:0]               mxlo4_q;
  logic signed [36:0]        mxhi4_q;
  logic signed [37:0]        y4_q;
  logic signed [AP_W-1:0]    ap4_q;
  // final
  stage_t                    st5_q;
  logic signed [NUM_W-1:0]   num5_q;
  logic signed [AP_W-1:0]    ap5_q;

  assign base_w = {1'b0, diff_i, 2'b00} + {2'b00, conv_i, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[COMB_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q  <= in_i;
    en1_q  <= DIFF_W'(in_i.item.e) + DIFF_W'(in_i.item.n);
    ws1_q  <= DIFF_W'(in_i.item.w) + DIFF_W'(in_i.item.s);
    md1_q  <= 17'(conv_i) + 17'(diff_i);
    pew1_q <= PSUM_W'(phi_i[0]) + PSUM_W'(phi_i[3]);
    pns1_q <= PSUM_W'(phi_i[1]) + PSUM_W'(phi_i[2]);
    pen1_q <= PSUM_W'(phi_i[0]) + PSUM_W'(phi_i[1]);
    pw1_q  <= phi_i[3];
    ps1_q  <= phi_i[2];

    st2_q   <= st1_q;
    wpew2_q <= st1_q.item.w * pew1_q;
    spns2_q <= st1_q.item.s * pns1_q;
    wwpw2_q <= st1_q.item.ww * pw1_q;
    ssps2_q <= st1_q.item.ss * ps1_q;
    den2_q  <= $signed({1'b0, diff_i}) * en1_q;
    mdws2_q <= $signed({1'b0, md1_q}) * ws1_q;
    mpen2_q <= $signed({1'b0, conv_i}) * pen1_q;

    st3_q <= st2_q;
    x3_q  <= 41'(wpew2_q) + 41'(spns2_q) - 41'(wwpw2_q) - 41'(ssps2_q);
    y3_q  <= 38'(den2_q) + 38'(mdws2_q);
    ap3_q <= AP_W'($signed({1'b0, base_w, 17'b0})) + AP_W'(mpen2_q);

    st4_q   <= st3_q;
    mxlo4_q <= 37'(conv_i) * 37'(x3_q[20:0]);
    mxhi4_q <= $signed({1'b0, conv_i}) * $signed(x3_q[40:21]);
    y4_q    <= y3_q;
    ap4_q   <= ap3_q;

    st5_q  <= st4_q;
    num5_q <= (NUM_W'(y4_q) <<< 17) + (NUM_W'(mxhi4_q) <<< 21) + $signed(NUM_W'(mxlo4_q));
    ap5_q  <= ap4_q;
  end

  assign out_valid_o = v_q[COMB_STAGES-1];
  assign out_o       = st5_q;
  assign num_o       = num5_q;
  assign ap_o        = ap5_q;

endmodule

// File: rtl/tvd_limited_cell_update.sv
// Top level: TVD-limited Gauss-Seidel cell update with over-relaxation.
//
// Command input: a cell (center, six stencil neighbors, edge_cell and
// force_upwind) is taken at each clock edge where start is high and busy
// is low. busy stays low, so a new cell may be issued every cycle.
// Results come out on new_val_o, abs_change_o and ratio_saturated_o for one
// cycle, marked by out_valid_o, in issue order. Sustained rate is one cell
// per clock. The pipeline holds three sets of bit-serial dividers: 20 stages
// for the gradient ratios, 18 for the Koren limiter quotient and 18 for the
// division by the center coefficient, plus multiplier and alignment stages.
// The result side has no backpressure; every result is shown once.
// Configuration: cfg_valid_i/cfg_ready_o write beats carry a register
// index and data; cfg_ready_o is always high. Write only while no cells
// are in flight.
// Reset clears all pipeline valids and loads the register defaults
// (upwind, both coefficients 2048, relaxation factor 1.0).
module tvd_limited_cell_update (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tlcu_pkg::val_t   center_val_i,
  input  tlcu_pkg::val_t   east_val_i,
  input  tlcu_pkg::val_t   west_val_i,
  input  tlcu_pkg::val_t   far_west_val_i,
  input  tlcu_pkg::val_t   north_val_i,
  input  tlcu_pkg::val_t   south_val_i,
  input  tlcu_pkg::val_t   far_south_val_i,
  input  logic             edge_cell_i,
  input  logic             force_upwind_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [16:0]      cfg_data_i,
  output logic             out_valid_o,
  output tlcu_pkg::val_t   new_val_o,
  output logic [17:0]      abs_change_o,
  output logic             ratio_saturated_o
);
  import tlcu_pkg::*;

  localparam int LAT = 2 + (RATIO_QB + 1) + 1 + (KOREN_QB + 1) + 1 + COMB_STAGES + 1 +
                       (G_QB + 1) + 5;
  localparam int RDW    = ABS_W + 16;
  localparam int ITEM_W = $bits(item_t);

  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic num_neg;
    logic neg;
  } lane_t;

  typedef struct packed {
    val_t c;
    logic edge_cell;
    logic flag;
    logic neg;
    logic ap_zero;
    logic num_zero;
    logic num_neg;
  } gside_t;

  typedef struct packed {
    val_t g;
    val_t c;
    logic edge_cell;
    logic flag;
  } tail_t;

  localparam int LANE_W  = $bits(lane_t);
  localparam int GSIDE_W = $bits(gside_t);

  // configuration
  logic [2:0]  lim_mode_q;
  logic [15:0] conv_q, diff_q;
  logic [16:0] relax_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_mode_q <= 3'(MODE_UPWIND);
      conv_q     <= 16'd2048;
      diff_q     <= 16'd2048;
      relax_q    <= 17'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LIMITER_MODE: lim_mode_q <= cfg_data_i[2:0];
        REG_CONV_COEF:    conv_q     <= cfg_data_i[15:0];
        REG_DIFF_COEF:    diff_q     <= cfg_data_i[15:0];
        REG_RELAX:        relax_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 0: capture
  logic  v0_q;
  item_t it0_q;
  mode_e mode_d;

  always_comb begin
    if ((lim_mode_q > 3'(MODE_MINMOD)) || edge_cell_i || force_upwind_i) mode_d = MODE_UPWIND;
    else mode_d = mode_e'(lim_mode_q);
  end

  // stage 1: differences
  logic                     v1_q;
  item_t                    it1_q;
  logic [ABS_W-1:0]         an1_q [4];
  logic [ABS_W-1:0]         ad1_q [4];
  lane_t                    ln1_q [4];
  logic signed [DIFF_W-1:0] lnum_w [4];
  logic signed [DIFF_W-1:0] lden_w [4];

  always_comb begin
    lnum_w[0] = DIFF_W'(it0_q.e)  - DIFF_W'(it0_q.c);
    lden_w[0] = DIFF_W'(it0_q.c)  - DIFF_W'(it0_q.w);
    lnum_w[1] = DIFF_W'(it0_q.n)  - DIFF_W'(it0_q.c);
    lden_w[1] = DIFF_W'(it0_q.c)  - DIFF_W'(it0_q.s);
    lnum_w[2] = DIFF_W'(it0_q.c)  - DIFF_W'(it0_q.s);
    lden_w[2] = DIFF_W'(it0_q.s)  - DIFF_W'(it0_q.ss);
    lnum_w[3] = DIFF_W'(it0_q.c)  - DIFF_W'(it0_q.w);
    lden_w[3] = DIFF_W'(it0_q.w)  - DIFF_W'(it0_q.ww);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    it0_q.c         <= center_val_i;
    it0_q.e         <= east_val_i;
    it0_q.w         <= west_val_i;
    it0_q.ww        <= far_west_val_i;
    it0_q.n         <= north_val_i;
    it0_q.s         <= south_val_i;
    it0_q.ss        <= far_south_val_i;
    it0_q.edge_cell <= edge_cell_i;
    it0_q.mode      <= mode_d;
    it1_q           <= it0_q;
    for (int k = 0; k < 4; k++) begin
      an1_q[k] <= lnum_w[k][DIFF_W-1] ? ABS_W'(-lnum_w[k]) : ABS_W'(lnum_w[k]);
      ad1_q[k] <= lden_w[k][DIFF_W-1] ? ABS_W'(-lden_w[k]) : ABS_W'(lden_w[k]);
      ln1_q[k].den_zero <= lden_w[k] == '0;
      ln1_q[k].num_zero <= lnum_w[k] == '0;
      ln1_q[k].num_neg  <= lnum_w[k][DIFF_W-1];
      ln1_q[k].neg      <= lnum_w[k][DIFF_W-1] ^ lden_w[k][DIFF_W-1];
    end
  end

  // ratio dividers
  logic [RATIO_QB-1:0] rq   [4];
  logic                rovf [4];
  lane_t               rln  [4];
  item_t               rit;
  logic                rv;

  for (genvar k = 0; k < 4; k++) begin : g_ratio
    if (k == 0) begin : g_lead
      tlcu_div #(.DW(RDW), .VW(ABS_W), .QB(RATIO_QB), .SW(ITEM_W + LANE_W)) u_div (
        .clk_i, .rst_ni,
        .in_valid_i  (v1_q),
        .dividend_i  ({an1_q[k], 16'b0}),
        .divisor_i   (ad1_q[k]),
        .side_i      ({it1_q, ln1_q[k]}),
        .out_valid_o (rv),
        .quot_o      (rq[k]),
        .ovf_o       (rovf[k]),
        .side_o      ({rit, rln[k]})
      );
    end else begin : g_lane
      tlcu_div #(.DW(RDW), .VW(ABS_W), .QB(RATIO_QB), .SW(LANE_W)) u_div (
        .clk_i, .rst_ni,
        .in_valid_i  (v1_q),
        .dividend_i  ({an1_q[k], 16'b0}),
        .divisor_i   (ad1_q[k]),
        .side_i      (ln1_q[k]),
        .out_valid_o (),
        .quot_o      (rq[k]),
        .ovf_o       (rovf[k]),
        .side_o      (rln[k])
      );
    end
  end

  // stage 2: ratio saturation
  ratio_t r_d [4];
  logic   rflag_d;
  logic   v2_q;
  stage_t st2_q;
  ratio_t r2_q [4];

  always_comb begin
    rflag_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (rln[k].den_zero) begin
        r_d[k]  = rln[k].num_zero ? ratio_t'(0) : (rln[k].num_neg ? RATIO_MIN : RATIO_MAX);
        rflag_d = 1'b1;
      end else if (rln[k].neg) begin
        if (rovf[k] || (rq[k] > 20'd524288)) begin
          r_d[k]  = RATIO_MIN;
          rflag_d = 1'b1;
        end else begin
          r_d[k] = ratio_t'(0) - ratio_t'(rq[k]);
        end
      end else begin
        if (rovf[k] || (rq[k] > 20'd524287)) begin
          r_d[k]  = RATIO_MAX;
          rflag_d = 1'b1;
        end else begin
          r_d[k] = ratio_t'(rq[k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= rv;
    end
  end

  always_ff @(posedge clk_i) begin
    st2_q.item <= rit;
    st2_q.flag <= rflag_d;
    r2_q       <= r_d;
  end

  // limiter and coefficients
  logic   lv;
  stage_t lst;
  ratio_t phi [4];

  tlcu_limiter u_limiter (
    .clk_i, .rst_ni,
    .in_valid_i  (v2_q),
    .in_i        (st2_q),
    .ratio_i     (r2_q),
    .out_valid_o (lv),
    .out_o       (lst),
    .phi_o       (phi)
  );

  logic                   cv;
  stage_t                 cst;
  logic signed [NUM_W-1:0] num;
  logic signed [AP_W-1:0]  ap;

  tlcu_combine u_combine (
    .clk_i, .rst_ni,
    .in_valid_i  (lv),
    .in_i        (lst),
    .phi_i       (phi),
    .conv_i      (conv_q),
    .diff_i      (diff_q),
    .out_valid_o (cv),
    .out_o       (cst),
    .num_o       (num),
    .ap_o        (ap)
  );

  // stage 3: magnitudes for the center division
  logic            v3_q;
  logic [UN_W-1:0] un3_q;
  logic [UD_W-1:0] ud3_q;
  gside_t          gs3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= cv;
    end
  end

  always_ff @(posedge clk_i) begin
    un3_q          <= num[NUM_W-1] ? UN_W'(-num) : UN_W'(num);
    ud3_q          <= ap[AP_W-1] ? UD_W'(-ap) : UD_W'(ap);
    gs3_q.c        <= cst.item.c;
    gs3_q.edge_cell <= cst.item.edge_cell;
    gs3_q.flag     <= cst.flag;
    gs3_q.neg      <= num[NUM_W-1] ^ ap[AP_W-1];
    gs3_q.ap_zero  <= ap == '0;
    gs3_q.num_zero <= num == '0;
    gs3_q.num_neg  <= num[NUM_W-1];
  end

  logic            gv;
  logic [G_QB-1:0] gq;
  logic            govf;
  gside_t          gs;

  tlcu_div #(.DW(UN_W), .VW(UD_W), .QB(G_QB), .SW(GSIDE_W)) u_gdiv (
    .clk_i, .rst_ni,
    .in_valid_i  (v3_q),
    .dividend_i  (un3_q),
    .divisor_i   (ud3_q),
    .side_i      (gs3_q),
    .out_valid_o (gv),
    .quot_o      (gq),
    .ovf_o       (govf),
    .side_o      (gs)
  );

  // stage 4: Gauss-Seidel value
  tail_t t4_d;

  always_comb begin
    t4_d.c         = gs.c;
    t4_d.edge_cell = gs.edge_cell;
    t4_d.flag      = gs.flag;
    if (gs.ap_zero) begin
      t4_d.g    = gs.num_zero ? val_t'(0) : (gs.num_neg ? VAL_MIN : VAL_MAX);
      t4_d.flag = 1'b1;
    end else if (gs.neg) begin
      t4_d.g = (govf || (gq > 18'd131072)) ? VAL_MIN : val_t'(0) - val_t'(gq);
    end else begin
      t4_d.g = (govf || (gq > 18'd131071)) ? VAL_MAX : val_t'(gq);
    end
  end

  // stages 4 to 8: relaxation
  logic                     v4_q, v5_q, v6_q, v7_q, out_v_q;
  tail_t                    t4_q, t5_q, t6_q;
  logic signed [DIFF_W-1:0] gd5_q;
  logic signed [36:0]       prod6_q;
  logic signed [20:0]       sh_w;
  logic signed [21:0]       sum_w;
  val_t                     nv_d, nv7_q, c7_q;
  logic                     flag7_q;
  logic signed [DIFF_W-1:0] chg_w;

  always_comb begin
    sh_w = 21'(prod6_q >>> 16);
    if (prod6_q[36] && (prod6_q[15:0] != '0)) sh_w = sh_w + 21'sd1;
    sum_w = 22'(t6_q.c) + 22'(sh_w);
    if (sum_w > 22'(VAL_MAX)) nv_d = VAL_MAX;
    else if (sum_w < 22'(VAL_MIN)) nv_d = VAL_MIN;
    else nv_d = val_t'(sum_w);
    if (t6_q.edge_cell) nv_d = t6_q.g;
    chg_w = DIFF_W'(nv7_q) - DIFF_W'(c7_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v4_q    <= gv;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      out_v_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t4_q              <= t4_d;
    t5_q              <= t4_q;
    gd5_q             <= DIFF_W'(t4_q.g) - DIFF_W'(t4_q.c);
    t6_q              <= t5_q;
    prod6_q           <= $signed({1'b0, relax_q}) * gd5_q;
    nv7_q             <= nv_d;
    c7_q              <= t6_q.c;
    flag7_q           <= t6_q.flag;
    new_val_o         <= nv7_q;
    abs_change_o      <= chg_w[DIFF_W-1] ? 18'(-chg_w) : 18'(chg_w);
    ratio_saturated_o <= flag7_q;
  end

  assign out_valid_o = out_v_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy, LAT))
    else $error("result without a matching command");

  a_upwind_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lv && (lst.item.mode == MODE_UPWIND)) |-> !lst.flag)
    else $error("ratio flag raised in upwind mode");

  a_gdiv_follows_comb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gv |-> $past(cv, G_QB + 2))
    else $error("center division result without coefficient beat");
`endif

endmodule

// File: tb/tb_tvd_limited_cell_update.sv
// Testbench for the TVD-limited cell update: directed and random cells checked against a predictor.
module tb_tvd_limited_cell_update;
  timeunit 1ns;
  timeprecision 1ps;
  import tlcu_pkg::*;

  localparam int LATENCY = 74;
  localparam longint V_MAX = 131071;
  localparam longint V_MIN = -131072;
  localparam longint R_MAX = 524287;
  localparam longint R_MIN = -524288;
  localparam longint Q16 = 65536;

  typedef struct {
    logic [17:0] new_val;
    logic [17:0] abs_change;
    logic        ratio_sat;
  } cell_res_t;

  class cell_scoreboard;
    cell_res_t pending[$];
    int errors;
    logic [2:0]  mode;
    logic [15:0] conv;
    logic [15:0] diff;
    logic [16:0] relax;

    function void load_defaults();
      mode = MODE_UPWIND;
      conv = 16'd2048;
      diff = 16'd2048;
      relax = 17'd65536;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [16:0] data);
      case (idx)
        REG_LIMITER_MODE: mode = data[2:0];
        REG_CONV_COEF:    conv = data[15:0];
        REG_DIFF_COEF:    diff = data[15:0];
        REG_RELAX:        relax = data;
        default: ;
      endcase
    endfunction

    function longint grad_ratio(longint num, longint den, inout bit sat);
      bit neg;
      longint an, ad, q;
      if (den == 0) begin
        sat = 1;
        return num > 0 ? R_MAX : (num < 0 ? R_MIN : 0);
      end
      neg = (num < 0) != (den < 0);
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = (an <<< 16) / ad;
      if (!neg && q > R_MAX) begin
        sat = 1;
        return R_MAX;
      end
      if (neg && q > 524288) begin
        sat = 1;
        return R_MIN;
      end
      return neg ? -q : q;
    endfunction

    function longint limiter_weight(logic [2:0] m, longint r);
      longint t;
      case (m)
        MODE_CENTRAL: return Q16;
        MODE_RATIO:   return r;
        MODE_KOREN: begin
          if (r <= 0) return 0;
          t = (r <<< 18) / (r + 3 * Q16);
          if (t > 2 * Q16) t = 2 * Q16;
          if (t > 2 * r) t = 2 * r;
          return t;
        end
        MODE_MINMOD: begin
          if (r < 0) return 0;
          return r > Q16 ? Q16 : r;
        end
        default: return 0;
      endcase
    endfunction

    function longint clamp_val(longint x);
      if (x > V_MAX) return V_MAX;
      if (x < V_MIN) return V_MIN;
      return x;
    endfunction

    function void note_cell(val_t c_i, val_t e_i, val_t w_i, val_t ww_i, val_t n_i,
                            val_t s_i, val_t ss_i, logic edge_i, logic force_i);
      longint c, e, w, ww, n, s, ss, re, rn, rs, rw, pe, pn, ps, pw;
      longint m, d, ae, aw, an, as_, aww, ass, ap, num, g, nv, dv, q, prod;
      logic [2:0] em;
      bit rsat, sat, neg;
      cell_res_t r;
      c = c_i; e = e_i; w = w_i; ww = ww_i; n = n_i; s = s_i; ss = ss_i;
      m = conv; d = diff;
      rsat = 0; sat = 0;
      em = (mode > 3'd4 || edge_i || force_i) ? 3'd0 : mode;
      re = grad_ratio(e - c, c - w, rsat);
      rn = grad_ratio(n - c, c - s, rsat);
      rs = grad_ratio(c - s, s - ss, rsat);
      rw = grad_ratio(c - w, w - ww, rsat);
      if (em >= 3'd2) sat = rsat;
      pe = limiter_weight(em, re);
      pn = limiter_weight(em, rn);
      ps = limiter_weight(em, rs);
      pw = limiter_weight(em, rw);
      ae = d * 131072;
      an = ae;
      aw = m * (pe + pw) + m * 131072 + d * 131072;
      as_ = m * (pn + ps) + m * 131072 + d * 131072;
      aww = -(m * pw);
      ass = -(m * ps);
      ap = ae + aw + an + as_ + aww + ass;
      num = e * ae + w * aw + ww * aww + n * an + s * as_ + ss * ass;
      if (ap == 0) begin
        sat = 1;
        g = num > 0 ? V_MAX : (num < 0 ? V_MIN : 0);
      end else begin
        neg = (num < 0) != (ap < 0);
        q = (num < 0 ? -num : num) / (ap < 0 ? -ap : ap);
        if (q > 262144) q = 262144;
        g = clamp_val(neg ? -q : q);
      end
      if (edge_i) nv = g;
      else begin
        prod = longint'(relax) * (g - c);
        nv = clamp_val(c + prod / Q16);
      end
      dv = nv - c;
      if (dv < 0) dv = -dv;
      r.new_val = nv[17:0];
      r.abs_change = dv[17:0];
      r.ratio_sat = sat;
      pending.push_back(r);
    endfunction

    function void check_result(logic [17:0] nv, logic [17:0] ac, logic fl);
      cell_res_t x;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (nv !== x.new_val) begin
        $error("new_val exp %0h got %0h", x.new_val, nv); errors++;
      end
      if (ac !== x.abs_change) begin
        $error("abs_change exp %0h got %0h", x.abs_change, ac); errors++;
      end
      if (fl !== x.ratio_sat) begin
        $error("ratio_saturated exp %0b got %0b", x.ratio_sat, fl); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  val_t center_val_i = '0, east_val_i = '0, west_val_i = '0, far_west_val_i = '0;
  val_t north_val_i = '0, south_val_i = '0, far_south_val_i = '0;
  logic edge_cell_i = 0, force_upwind_i = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;
  logic out_valid_o;
  val_t new_val_o;
  logic [17:0] abs_change_o;
  logic ratio_saturated_o;

  cell_scoreboard sb = new();

  tvd_limited_cell_update DUT (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o) sb.check_result(new_val_o, abs_change_o, ratio_saturated_o);

  task automatic idle_gap();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) k = 0;
    else if (k < 9) k = $urandom_range(1, 3);
    else k = $urandom_range(4, 30);
    if (k > 0) begin
      start <= 0;
      repeat (k) @(posedge clk_i);
    end
  endtask

  task automatic send_cell(val_t c, val_t e, val_t w, val_t ww, val_t n, val_t s,
                           val_t ss, logic ed, logic fu, bit gaps);
    center_val_i <= c; east_val_i <= e; west_val_i <= w; far_west_val_i <= ww;
    north_val_i <= n; south_val_i <= s; far_south_val_i <= ss;
    edge_cell_i <= ed; force_upwind_i <= fu;
    start <= 1;
    do @(posedge clk_i); while (busy);
    sb.note_cell(c, e, w, ww, n, s, ss, ed, fu);
    if (gaps) idle_gap();
  endtask

  task automatic settle();
    start <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [16:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic val_t rand_val();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return VAL_MAX;
    if (k == 1) return VAL_MIN;
    if (k < 5) return val_t'($urandom_range(0, 8191)) - 18'sd4096;
    return val_t'($urandom());
  endfunction

  task automatic random_cell(bit gaps);
    val_t c, e, w, ww, n, s, ss;
    int k;
    c = rand_val(); e = rand_val(); w = rand_val(); ww = rand_val();
    n = rand_val(); s = rand_val(); ss = rand_val();
    k = $urandom_range(0, 15);
    if (k == 0) w = c;
    if (k == 1) s = c;
    if (k == 2) ww = w;
    if (k == 3) ss = s;
    if (k == 4) begin
      // smooth field gives moderate ratios
      w = c - val_t'($urandom_range(0, 2000));
      ww = w - val_t'($urandom_range(0, 2000));
      e = c + val_t'($urandom_range(0, 2000));
    end
    send_cell(c, e, w, ww, n, s, ss, $urandom_range(0, 7) == 0,
              $urandom_range(0, 7) == 0, gaps);
  endtask

  initial begin
    #200000;
    $display("tvd_limited_cell_update test failed");
    $finish;
  end

  initial begin
    int ph;
    logic [16:0] relax_set[6];
    logic [15:0] coef_set[6];
    relax_set = '{17'd0, 17'd131071, 17'd65536, 17'd98304, 17'd1, 17'd40000};
    coef_set = '{16'd0, 16'd65535, 16'd2048, 16'd1, 16'd30000, 16'd500};
    sb.load_defaults();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, edge and forced cells, zero denominators
    for (int md = 0; md < 8; md++) begin
      write_reg(REG_LIMITER_MODE, 17'(md));
      send_cell(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX,
                1'b0, 1'b0, 1'b0);
      send_cell(18'sd100, 18'sd200, 18'sd100, 18'sd50, 18'sd100, 18'sd100, 18'sd7,
                1'b0, 1'b0, 1'b0);
      send_cell(18'sd0, 18'sd1000, -18'sd500, -18'sd900, 18'sd300, -18'sd200,
                -18'sd400, md[0], md[1], 1'b0);
      settle();
    end
    write_reg(REG_CONV_COEF, 17'd0);
    write_reg(REG_DIFF_COEF, 17'd0);
    send_cell(18'sd5, 18'sd9, 18'sd1, 18'sd3, 18'sd4, -18'sd2, 18'sd0, 1'b0, 1'b0, 1'b0);
    send_cell(18'sd5, -18'sd9, 18'sd1, 18'sd3, -18'sd4, -18'sd2, 18'sd0, 1'b1, 1'b0, 1'b0);
    settle();

    for (ph = 0; ph < 12; ph++) begin
      write_reg(REG_LIMITER_MODE, 17'($urandom_range(0, 7)));
      write_reg(REG_CONV_COEF, 17'(coef_set[$urandom_range(0, 5)]));
      write_reg(REG_DIFF_COEF, (ph == 3) ? 17'd0 : 17'(coef_set[$urandom_range(0, 5)]));
      write_reg(REG_RELAX, relax_set[ph % 6]);
      for (int i = 0; i < 140; i++) random_cell(ph % 3 != 2);
      settle();
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tvd_limited_cell_update test passed");
    else
      $display("tvd_limited_cell_update test failed");
    $finish;
  end
endmodule
